[design/gils_pkg.sv]
// shared constants, types and helpers for the graph incidence list store
`timescale 1ns / 1ps

package gils_pkg;

  // sizing of the store
  localparam int NUM_VERTICES = 64;
  localparam int MAX_DEGREE   = 16;

  // fixed field widths
  localparam int CMD_W     = 2;
  localparam int VTX_W     = 6;
  localparam int WGT_W     = 16;
  localparam int IDX_W     = 4;
  localparam int STATUS_W  = 2;
  localparam int DEG_OUT_W = 5;

  // derived widths
  localparam int DEG_W   = $clog2(MAX_DEGREE + 1);
  localparam int VTX_AW  = $clog2(NUM_VERTICES);
  localparam int SLOT_W  = $clog2(MAX_DEGREE);
  localparam int SLOT_AW = $clog2(NUM_VERTICES * MAX_DEGREE);
  localparam int SLOT_DW = VTX_W + WGT_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  // which vertex drives the degree memory read port
  typedef enum logic [1:0] {
    RD_SEL_A,
    RD_SEL_B,
    RD_SEL_Q
  } rd_sel_e;

  // controller to datapath
  typedef struct packed {
    logic    latch;
    rd_sel_e rd_sel;
    logic    cap_a;
    logic    ins_check;
    logic    ins_second;
    logic    q_check;
    logic    finish;
  } gils_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic ins_ok;
  } gils_stat_t;

  // flat slot address of a vertex's slot
  function automatic logic [SLOT_AW-1:0] slot_addr(input logic [VTX_W-1:0] vtx,
                                                   input logic [SLOT_W-1:0] slot);
    slot_addr = SLOT_AW'(int'(vtx) * MAX_DEGREE + int'(slot));
  endfunction

endpackage

[design/gils_ram.sv]
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module gils_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/gils_ctrl.sv]
// sequencing state machine for the incidence list store
`timescale 1ns / 1ps

module gils_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [gils_pkg::CMD_W-1:0] cmd_i,
  input  gils_pkg::gils_stat_t      stat_i,
  output gils_pkg::gils_ctrl_t      ctrl_o,
  output logic                      busy_o,
  output logic                      done_o
);

  import gils_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_CHECK,
    S_WR_B,
    S_RD_Q,
    S_Q_CHECK,
    S_FINISH
  } state_e;

  state_e state_q;
  logic   done_q;

  // command decode per state
  always_comb begin
    ctrl_o = '0;
    ctrl_o.rd_sel = RD_SEL_Q;
    case (state_q)
      S_IDLE:    ctrl_o.latch = start_i;
      S_RD_A:    ctrl_o.rd_sel = RD_SEL_A;
      S_RD_B: begin
        ctrl_o.rd_sel = RD_SEL_B;
        ctrl_o.cap_a  = 1'b1;
      end
      S_CHECK:   ctrl_o.ins_check = 1'b1;
      S_WR_B:    ctrl_o.ins_second = 1'b1;
      S_RD_Q:    ctrl_o.rd_sel = RD_SEL_Q;
      S_Q_CHECK: ctrl_o.q_check = 1'b1;
      S_FINISH:  ctrl_o.finish = 1'b1;
      default:   ctrl_o = '0;
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            case (cmd_i)
              CMD_INSERT: state_q <= S_RD_A;
              CMD_QUERY:  state_q <= S_RD_Q;
              default:    state_q <= S_FINISH;
            endcase
          end
        end
        S_RD_A:    state_q <= S_RD_B;
        S_RD_B:    state_q <= S_CHECK;
        S_CHECK:   state_q <= stat_i.ins_ok ? S_WR_B : S_FINISH;
        S_WR_B:    state_q <= S_FINISH;
        S_RD_Q:    state_q <= S_Q_CHECK;
        S_Q_CHECK: state_q <= S_FINISH;
        S_FINISH: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default:   state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

[design/gils_dp.sv]
// datapath: request registers, degree and slot memories, result registers
`timescale 1ns / 1ps

module gils_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gils_pkg::gils_ctrl_t              ctrl_i,
  output gils_pkg::gils_stat_t              stat_o,
  input  logic [gils_pkg::CMD_W-1:0]        cmd_i,
  input  logic [gils_pkg::VTX_W-1:0]        edge_from_i,
  input  logic [gils_pkg::VTX_W-1:0]        edge_to_i,
  input  logic signed [gils_pkg::WGT_W-1:0] edge_weight_i,
  input  logic [gils_pkg::VTX_W-1:0]        query_vertex_i,
  input  logic [gils_pkg::IDX_W-1:0]        query_index_i,
  output logic [gils_pkg::STATUS_W-1:0]     status_o,
  output logic [gils_pkg::DEG_OUT_W-1:0]    degree_o,
  output logic [gils_pkg::VTX_W-1:0]        near_end_o,
  output logic [gils_pkg::VTX_W-1:0]        far_end_o,
  output logic signed [gils_pkg::WGT_W-1:0] result_weight_o
);

  import gils_pkg::*;

  // request registers
  logic [CMD_W-1:0]        cmd_q;
  logic [VTX_W-1:0]        from_q;
  logic [VTX_W-1:0]        to_q;
  logic signed [WGT_W-1:0] wgt_q;
  logic [VTX_W-1:0]        qv_q;
  logic [IDX_W-1:0]        qi_q;

  // working registers
  logic [DEG_W-1:0] deg_a_q;
  logic [DEG_W-1:0] deg_b_q;
  status_e          status_q;
  logic             rd_vld_q;
  logic [NUM_VERTICES-1:0] deg_vld_q;

  // result registers
  logic [STATUS_W-1:0]     res_status_q;
  logic [DEG_OUT_W-1:0]    res_degree_q;
  logic [VTX_W-1:0]        res_near_q;
  logic [VTX_W-1:0]        res_far_q;
  logic signed [WGT_W-1:0] res_wgt_q;

  // memory ports
  logic [VTX_AW-1:0]  deg_raddr;
  logic [VTX_AW-1:0]  deg_waddr;
  logic [DEG_W-1:0]   deg_wdata;
  logic [DEG_W-1:0]   deg_rdata;
  logic               deg_we;
  logic [SLOT_AW-1:0] slot_raddr;
  logic [SLOT_AW-1:0] slot_waddr;
  logic [SLOT_DW-1:0] slot_wdata;
  logic [SLOT_DW-1:0] slot_rdata;
  logic               slot_we;

  // derived values
  logic [DEG_W-1:0] deg_rd;
  logic             ins_oor;
  logic             self_loop;
  logic             ins_ok;
  logic [DEG_W-1:0] deg_b_nxt;
  logic             q_oor;
  logic             q_hit;
  logic [DEG_W-1:0] q_pos;

  gils_ram #(
    .WIDTH(DEG_W),
    .DEPTH(NUM_VERTICES)
  ) u_deg_ram (
    .clk_i  (clk_i),
    .we_i   (deg_we),
    .waddr_i(deg_waddr),
    .wdata_i(deg_wdata),
    .raddr_i(deg_raddr),
    .rdata_o(deg_rdata)
  );

  gils_ram #(
    .WIDTH(SLOT_DW),
    .DEPTH(NUM_VERTICES * MAX_DEGREE)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(slot_waddr),
    .wdata_i(slot_wdata),
    .raddr_i(slot_raddr),
    .rdata_o(slot_rdata)
  );

  // degree read address select
  always_comb begin
    case (ctrl_i.rd_sel)
      RD_SEL_A: deg_raddr = VTX_AW'(from_q);
      RD_SEL_B: deg_raddr = VTX_AW'(to_q);
      default:  deg_raddr = VTX_AW'(qv_q);
    endcase
  end

  // an entry never written since the last clear reads as zero
  assign deg_rd = rd_vld_q ? deg_rdata : '0;

  // insert fit check
  assign ins_oor   = (int'(from_q) >= NUM_VERTICES) || (int'(to_q) >= NUM_VERTICES);
  assign self_loop = (from_q == to_q);
  always_comb begin
    if (ins_oor) begin
      ins_ok = 1'b0;
    end else if (self_loop) begin
      ins_ok = (int'(deg_a_q) + 2 <= MAX_DEGREE);
    end else begin
      ins_ok = (int'(deg_a_q) < MAX_DEGREE) && (int'(deg_rd) < MAX_DEGREE);
    end
  end
  // a self-loop's second copy lands after the first
  assign deg_b_nxt = self_loop ? deg_a_q + DEG_W'(1) : deg_rd;
  assign stat_o.ins_ok = ins_ok;

  // query lookup, newest entry sits at the top of the slot array
  assign q_oor = (int'(qv_q) >= NUM_VERTICES);
  assign q_hit = !q_oor && (int'(qi_q) < int'(deg_rd));
  assign q_pos = deg_rd - DEG_W'(1) - DEG_W'(qi_q);
  assign slot_raddr = slot_addr(qv_q, SLOT_W'(q_pos));

  // memory writes for the two copies of an edge
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = slot_addr(from_q, SLOT_W'(deg_a_q));
    slot_wdata = {to_q, wgt_q};
    deg_we     = 1'b0;
    deg_waddr  = VTX_AW'(from_q);
    deg_wdata  = deg_a_q + DEG_W'(1);
    if (ctrl_i.ins_check && ins_ok) begin
      slot_we = 1'b1;
      deg_we  = 1'b1;
    end else if (ctrl_i.ins_second) begin
      slot_we    = 1'b1;
      slot_waddr = slot_addr(to_q, SLOT_W'(deg_b_q));
      slot_wdata = {from_q, wgt_q};
      deg_we     = 1'b1;
      deg_waddr  = VTX_AW'(to_q);
      deg_wdata  = deg_b_q + DEG_W'(1);
    end
  end

  // degree valid bits, cleared by reset and by a clear request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= deg_vld_q[deg_raddr];
      if (ctrl_i.finish && (cmd_q == CMD_CLEAR)) begin
        deg_vld_q <= '0;
      end else if (deg_we) begin
        deg_vld_q[deg_waddr] <= 1'b1;
      end
    end
  end

  // request capture and working registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      cmd_q  <= cmd_i;
      from_q <= edge_from_i;
      to_q   <= edge_to_i;
      wgt_q  <= edge_weight_i;
      qv_q   <= query_vertex_i;
      qi_q   <= query_index_i;
    end
    if (ctrl_i.cap_a) begin
      deg_a_q <= deg_rd;
    end
    if (ctrl_i.ins_check) begin
      deg_b_q  <= deg_b_nxt;
      status_q <= ins_ok ? ST_OK : ST_FULL;
    end
    if (ctrl_i.q_check) begin
      deg_a_q  <= q_oor ? '0 : deg_rd;
      status_q <= q_hit ? ST_OK : ST_MISS;
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.finish) begin
      res_status_q <= ST_OK;
      res_degree_q <= '0;
      res_near_q   <= '0;
      res_far_q    <= '0;
      res_wgt_q    <= '0;
      case (cmd_q)
        CMD_INSERT: res_status_q <= status_q;
        CMD_QUERY: begin
          res_status_q <= status_q;
          res_degree_q <= DEG_OUT_W'(deg_a_q);
          if (status_q == ST_OK) begin
            res_near_q <= qv_q;
            res_far_q  <= slot_rdata[SLOT_DW-1:WGT_W];
            res_wgt_q  <= slot_rdata[WGT_W-1:0];
          end
        end
        default: res_status_q <= ST_OK;
      endcase
    end
  end

  assign status_o        = res_status_q;
  assign degree_o        = res_degree_q;
  assign near_end_o      = res_near_q;
  assign far_end_o       = res_far_q;
  assign result_weight_o = res_wgt_q;

endmodule

[design/graph_incidence_list_store.sv]
// Incidence list store: a request is taken when start is high and busy low.
// The result strobe done_o rises after the FINISH state: a clear goes there directly,
// a query by RD_Q and Q_CHECK, an insert by RD_A, RD_B, CHECK and WR_B, and a dropped
// insert skips WR_B; a new request may be given in the strobe cycle.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (rst_ni, async, active low) empties every list; slot contents stay undefined.
`timescale 1ns / 1ps

module graph_incidence_list_store (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [gils_pkg::CMD_W-1:0]        cmd_i,
  input  logic [gils_pkg::VTX_W-1:0]        edge_from_i,
  input  logic [gils_pkg::VTX_W-1:0]        edge_to_i,
  input  logic signed [gils_pkg::WGT_W-1:0] edge_weight_i,
  input  logic [gils_pkg::VTX_W-1:0]        query_vertex_i,
  input  logic [gils_pkg::IDX_W-1:0]        query_index_i,
  output logic                              done_o,
  output logic [gils_pkg::STATUS_W-1:0]     status_o,
  output logic [gils_pkg::DEG_OUT_W-1:0]    degree_o,
  output logic [gils_pkg::VTX_W-1:0]        near_end_o,
  output logic [gils_pkg::VTX_W-1:0]        far_end_o,
  output logic signed [gils_pkg::WGT_W-1:0] result_weight_o
);

  import gils_pkg::*;

  gils_ctrl_t ctrl;
  gils_stat_t stat;

  // sequencer
  gils_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .cmd_i  (cmd_i),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy),
    .done_o (done_o)
  );

  // storage and result datapath
  gils_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .cmd_i          (cmd_i),
    .edge_from_i    (edge_from_i),
    .edge_to_i      (edge_to_i),
    .edge_weight_i  (edge_weight_i),
    .query_vertex_i (query_vertex_i),
    .query_index_i  (query_index_i),
    .status_o       (status_o),
    .degree_o       (degree_o),
    .near_end_o     (near_end_o),
    .far_end_o      (far_end_o),
    .result_weight_o(result_weight_o)
  );

  // an accepted request keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // a result only follows a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a request in flight");

  // a failed request carries no edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |->
      (near_end_o == '0 && far_end_o == '0 && result_weight_o == '0))
    else $error("edge fields set on a failed request");

  // the result strobe lasts a single cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

endmodule
